@@ hw/rtl/eight_zone_midpoint_line_assert.svh @@
// Assertion macros for the line rasterizer.
`ifndef EIGHT_ZONE_MIDPOINT_LINE_ASSERT_SVH
`define EIGHT_ZONE_MIDPOINT_LINE_ASSERT_SVH

`ifndef SYNTH
`define EZML_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define EZML_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define EZML_ASSERT_IMPLY(lbl, ante, cons)
`define EZML_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/ezml_pkg.sv @@
package ezml_pkg;

	localparam int COORD_BITS = 12;
	localparam int WIDE_BITS  = COORD_BITS + 1;
	localparam int STEP_BITS  = COORD_BITS + 2;
	localparam int DEC_BITS   = COORD_BITS + 4;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [WIDE_BITS-1:0]  wide_t;
	typedef logic        [STEP_BITS-1:0]  step_e_t;
	typedef logic signed [STEP_BITS-1:0]  step_d_t;
	typedef logic signed [DEC_BITS-1:0]   dec_t;
	typedef logic        [2:0]            oct_t;

	localparam coord_t COORD_MIN_PAT = coord_t'(1 << (COORD_BITS - 1));
	localparam coord_t COORD_SAT     = coord_t'(1 - (1 << (COORD_BITS - 1)));

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	localparam oct_t OCT_0 = 3'd0;
	localparam oct_t OCT_1 = 3'd1;
	localparam oct_t OCT_2 = 3'd2;
	localparam oct_t OCT_3 = 3'd3;
	localparam oct_t OCT_4 = 3'd4;
	localparam oct_t OCT_5 = 3'd5;
	localparam oct_t OCT_6 = 3'd6;
	localparam oct_t OCT_7 = 3'd7;

	typedef struct packed {
		coord_t p;
		coord_t q;
	} pair_t;

	typedef struct packed {
		oct_t    octant;
		coord_t  cur_major;
		coord_t  cur_minor;
		coord_t  end_major;
		dec_t    decision;
		step_e_t step_east;
		step_d_t step_diag;
	} setup_t;

	function automatic coord_t sat_coord(coord_t c);
		return (c == COORD_MIN_PAT) ? COORD_SAT : c;
	endfunction

	function automatic pair_t into_zero(coord_t x, coord_t y, oct_t o);
		pair_t r;
		case (o)
			OCT_0: begin r.p = x;  r.q = y;  end
			OCT_1: begin r.p = y;  r.q = x;  end
			OCT_2: begin r.p = y;  r.q = -x; end
			OCT_3: begin r.p = -x; r.q = y;  end
			OCT_4: begin r.p = -x; r.q = -y; end
			OCT_5: begin r.p = -y; r.q = -x; end
			OCT_6: begin r.p = -y; r.q = x;  end
			default: begin r.p = x; r.q = -y; end
		endcase
		return r;
	endfunction

	// p = x, q = y on return
	function automatic pair_t from_zero(coord_t a, coord_t b, oct_t o);
		pair_t r;
		case (o)
			OCT_0: begin r.p = a;  r.q = b;  end
			OCT_1: begin r.p = b;  r.q = a;  end
			OCT_2: begin r.p = -b; r.q = a;  end
			OCT_3: begin r.p = -a; r.q = b;  end
			OCT_4: begin r.p = -a; r.q = -b; end
			OCT_5: begin r.p = -b; r.q = -a; end
			OCT_6: begin r.p = b;  r.q = -a; end
			default: begin r.p = a; r.q = -b; end
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/ezml_cmd_if.sv @@
interface ezml_cmd_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	ezml_pkg::coord_t   x_start;
	ezml_pkg::coord_t   y_start;
	ezml_pkg::coord_t   x_end;
	ezml_pkg::coord_t   y_end;

	modport source (output valid, output opcode, output x_start, output y_start,
		output x_end, output y_end, input ready);
	modport sink (input valid, input opcode, input x_start, input y_start,
		input x_end, input y_end, output ready);
endinterface

@@ hw/rtl/ezml_pix_if.sv @@
interface ezml_pix_if;
	logic               valid;
	logic               ready;
	ezml_pkg::coord_t   pixel_x;
	ezml_pkg::coord_t   pixel_y;
	logic               last;

	modport source (output valid, output pixel_x, output pixel_y, output last,
		input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input last,
		output ready);
endinterface

@@ hw/rtl/eight_zone_midpoint_line.sv @@
// Eight-octant midpoint line rasterizer.
// cmd channel: one beat per command. opcode OP_START loads both endpoints
// and gives no pixel; any line in progress is dropped. opcode OP_STEP emits
// the next pixel of the current line; with no line active it is consumed
// and gives nothing.
// pix channel: one beat per pixel, pixel_x/pixel_y in the original frame,
// last set on the pixel equal to the second endpoint, after which the line
// is finished.
// A step beat's pixel is registered when the beat is accepted. Throughput:
// one command per cycle while cmd.ready is high, so one pixel per clock when
// steps are streamed; state updates are registered, setup math combinational.
// A single output register holds the pixel; cmd.ready is low only while
// that register is full and pix.ready is low, so a stalled receiver stops
// the command side and nothing is lost.
// Reset (arst_n low): no active line, output empty, state cleared.
`include "eight_zone_midpoint_line_assert.svh"

module eight_zone_midpoint_line (
	input logic     clk,
	input logic     arst_n,
	ezml_cmd_if.sink   cmd,
	ezml_pix_if.source pix
);
	import ezml_pkg::*;

	setup_t  setup;
	oct_t    octant_q;
	coord_t  cur_major_q, cur_minor_q, end_major_q;
	dec_t    decision_q;
	step_e_t step_east_q;
	step_d_t step_diag_q;
	logic    active_q;

	logic    pix_valid_q;
	coord_t  pix_x_q, pix_y_q;
	logic    pix_last_q;

	logic    cmd_fire, is_start, do_pixel, is_last;
	pair_t   pix_xy;
	dec_t    east_w, diag_w;

	ezml_setup u_setup (
		.x_start (cmd.x_start),
		.y_start (cmd.y_start),
		.x_end   (cmd.x_end),
		.y_end   (cmd.y_end),
		.setup   (setup)
	);

	assign cmd.ready   = !pix_valid_q || pix.ready;
	assign pix.valid   = pix_valid_q;
	assign pix.pixel_x = pix_x_q;
	assign pix.pixel_y = pix_y_q;
	assign pix.last    = pix_last_q;

	always_comb begin
		cmd_fire = cmd.valid && cmd.ready;
		is_start = (cmd.opcode == OP_START);
		do_pixel = cmd_fire && !is_start && active_q;
		is_last  = (cur_major_q == end_major_q);
		pix_xy   = from_zero(cur_major_q, cur_minor_q, octant_q);
		east_w   = {{(DEC_BITS-STEP_BITS){1'b0}}, step_east_q};
		diag_w   = {{(DEC_BITS-STEP_BITS){step_diag_q[STEP_BITS-1]}}, step_diag_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octant_q    <= OCT_0;
			cur_major_q <= '0;
			cur_minor_q <= '0;
			end_major_q <= '0;
			decision_q  <= '0;
			step_east_q <= '0;
			step_diag_q <= '0;
			active_q    <= 1'b0;
		end else if (cmd_fire && is_start) begin
			octant_q    <= setup.octant;
			cur_major_q <= setup.cur_major;
			cur_minor_q <= setup.cur_minor;
			end_major_q <= setup.end_major;
			decision_q  <= setup.decision;
			step_east_q <= setup.step_east;
			step_diag_q <= setup.step_diag;
			active_q    <= 1'b1;
		end else if (do_pixel) begin
			if (is_last) begin
				active_q <= 1'b0;
			end else begin
				cur_major_q <= cur_major_q + coord_t'(1);
				if (decision_q > 0) begin
					cur_minor_q <= cur_minor_q + coord_t'(1);
					decision_q  <= decision_q + diag_w;
				end else begin
					decision_q  <= decision_q + east_w;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (do_pixel) begin
			pix_valid_q <= 1'b1;
		end else if (pix.ready) begin
			pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_pixel) begin
			pix_x_q    <= pix_xy.p;
			pix_y_q    <= pix_xy.q;
			pix_last_q <= is_last;
		end
	end

	`EZML_ASSERT_NEXT(a_step_idle_no_pix, cmd_fire && !is_start && !active_q, !pix.valid)
	`EZML_ASSERT_NEXT(a_step_gives_pix, do_pixel, pix.valid)
	`EZML_ASSERT_NEXT(a_last_ends_line, do_pixel && is_last, !active_q && pix.last)
	`EZML_ASSERT_IMPLY(a_full_stall, pix_valid_q && !pix.ready, !cmd.ready)

endmodule

@@ hw/rtl/ezml_setup.sv @@
module ezml_setup (
	input  ezml_pkg::coord_t x_start,
	input  ezml_pkg::coord_t y_start,
	input  ezml_pkg::coord_t x_end,
	input  ezml_pkg::coord_t y_end,
	output ezml_pkg::setup_t setup
);
	import ezml_pkg::*;

	coord_t x0, y0, x1, y1;
	wide_t  dx, dy, dmaj, dmin;
	oct_t   oct;
	pair_t  e0, e1;
	dec_t   dmin_w, dmaj_w;

	always_comb begin
		x0 = sat_coord(x_start);
		y0 = sat_coord(y_start);
		x1 = sat_coord(x_end);
		y1 = sat_coord(y_end);
		dx = wide_t'(x1) - wide_t'(x0);
		dy = wide_t'(y1) - wide_t'(y0);

		if (!dx[WIDE_BITS-1] && !dy[WIDE_BITS-1]) begin
			oct = (dx > dy) ? OCT_0 : OCT_1;
		end else if (dx[WIDE_BITS-1] && !dy[WIDE_BITS-1]) begin
			oct = (-dx > dy) ? OCT_3 : OCT_2;
		end else if (dx[WIDE_BITS-1]) begin
			oct = (-dx > -dy) ? OCT_4 : OCT_5;
		end else begin
			oct = (dx > -dy) ? OCT_7 : OCT_6;
		end

		e0   = into_zero(x0, y0, oct);
		e1   = into_zero(x1, y1, oct);
		dmaj = wide_t'(e1.p) - wide_t'(e0.p);
		dmin = wide_t'(e1.q) - wide_t'(e0.q);
		dmaj_w = dec_t'(dmaj);
		dmin_w = dec_t'(dmin);

		setup.octant    = oct;
		setup.cur_major = e0.p;
		setup.cur_minor = e0.q;
		setup.end_major = e1.p;
		setup.decision  = (dmin_w <<< 1) - dmaj_w;
		setup.step_east = step_e_t'(dmin_w <<< 1);
		setup.step_diag = step_d_t'((dmin_w - dmaj_w) <<< 1);
	end

endmodule
